>>> hdl/ptts_pkg.sv
`timescale 1ns / 1ps
// Package for the periodic task tick scheduler.
// Holds request codes, slot entry and result types and sizing constants.
// No dependencies.
package ptts_pkg;

	localparam int TASK_SLOTS_DEF = 8;
	localparam int MAX_RESULTS    = 8;
	localparam int SLOT_W         = 3;
	localparam int TICKS_W        = 16;

	typedef enum logic [2:0] {
		REQ_TICK    = 3'd0,
		REQ_CREATE  = 3'd1,
		REQ_SUSPEND = 3'd2,
		REQ_RESUME  = 3'd3,
		REQ_DELETE  = 3'd4
	} req_type_t;

	typedef enum logic [1:0] {
		RS_EMPTY     = 2'd0,
		RS_RESUMED   = 2'd1,
		RS_SUSPENDED = 2'd2
	} run_state_t;

	typedef struct packed {
		logic               occupied;
		run_state_t         run_state;
		logic [TICKS_W-1:0] period;
		logic [TICKS_W-1:0] delay;
		logic               has_handler;
	} slot_entry_t;

	typedef struct packed {
		logic              status_code;
		logic              dispatch_valid;
		logic [SLOT_W-1:0] dispatch_slot;
		logic              last_result;
	} result_t;

endpackage

>>> hdl/ptts_slot_mem.sv
`timescale 1ns / 1ps
// Task slot table: one write port, one registered read port.
// Per-entry valid bits make unwritten slots read as an all-zero entry.
// Depends on ptts_pkg.
module ptts_slot_mem #(
	parameter int  SLOTS = ptts_pkg::TASK_SLOTS_DEF,
	localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output ptts_pkg::slot_entry_t rd_data,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  ptts_pkg::slot_entry_t wr_data
);
	import ptts_pkg::*;

	slot_entry_t             mem_q [SLOTS];
	logic        [SLOTS-1:0] valid_q;
	slot_entry_t             rd_data_q;
	logic                    rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

>>> hdl/ptts_out_reg.sv
`timescale 1ns / 1ps
// Result output register: decouples the sequencer from the result stall.
// Depends on ptts_pkg.
module ptts_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ptts_pkg::result_t res_in,
	output logic              can_push,
	output logic              out_valid,
	input  logic              out_stall,
	output ptts_pkg::result_t res_out
);
	import ptts_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign can_push  = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= res_in;
		end
	end

endmodule

>>> hdl/periodic_task_tick_scheduler.sv
`timescale 1ns / 1ps
// Periodic task tick scheduler, top level. Depends on ptts_pkg, ptts_slot_mem, ptts_out_reg.
// Create/suspend/resume/delete: each transaction reads its slot, then modifies it and writes it back.
// Tick: the slot walk reads one slot per cycle through the table read port while no result stall holds it.
// Results are registered and appear in the cycle after the producing step; result stall holds the walk.
// Reset (arst_n, asynchronous, active low) empties every slot through the table valid bits.
module periodic_task_tick_scheduler #(
	parameter int TASK_SLOTS = ptts_pkg::TASK_SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [2:0]                     req_type,
	input  logic [ptts_pkg::SLOT_W-1:0]    slot_index,
	input  logic [ptts_pkg::TICKS_W-1:0]   period_ticks,
	input  logic [ptts_pkg::TICKS_W-1:0]   start_delay,
	input  logic                           has_handler,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           status_code,
	output logic                           dispatch_valid,
	output logic [ptts_pkg::SLOT_W-1:0]    dispatch_slot,
	output logic                           last_result
);
	import ptts_pkg::*;

	// table address width and walk counter width (counter must hold TASK_SLOTS)
	localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int CW = $clog2(TASK_SLOTS + 1);
	localparam int NW = $clog2(MAX_RESULTS + 1);

	// one-hot sequencer
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_REQ  = 4'b0010,
		ST_WALK = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// latched request transaction
	req_type_t          req_q;
	logic [SW-1:0]      req_addr_q;
	logic               req_in_range_q;
	logic [TICKS_W-1:0] period_q;
	logic [TICKS_W-1:0] delay_q;
	logic               handler_q;

	// tick walk: read address counter, slot whose entry is in the read register,
	// and the most recent dispatch held back until we know whether it is the last
	logic [CW-1:0]     rd_cnt_q, rd_cnt_d;
	logic              proc_valid_s1, proc_valid_d;
	logic [SW-1:0]     proc_slot_s1, proc_slot_d;
	logic              pend_valid_q, pend_valid_d;
	logic [SLOT_W-1:0] pend_slot_q, pend_slot_d;
	logic [NW-1:0]     disp_cnt_q, disp_cnt_d;

	// table ports
	logic          rd_en, wr_en;
	logic [SW-1:0] rd_addr, wr_addr;
	slot_entry_t   rd_data, wr_data;

	// result register ports
	logic    push, can_push;
	result_t res, res_out;

	logic in_accept;
	logic in_range_in;

	// walk decode of the entry in the read register
	logic resumed, dispatch, record, emit_prev, walk_go;

	assign in_stall    = (state_q != ST_IDLE);
	assign in_accept   = in_valid && !in_stall;
	assign in_range_in = (32'(slot_index) < 32'(TASK_SLOTS));

	assign resumed   = (rd_data.run_state == RS_RESUMED);
	assign dispatch  = resumed && (rd_data.delay == '0) && rd_data.has_handler;
	assign record    = dispatch && (disp_cnt_q < NW'(MAX_RESULTS));
	assign emit_prev = record && pend_valid_q;
	assign walk_go   = proc_valid_s1 && (!emit_prev || can_push);

	ptts_slot_mem #(
		.SLOTS (TASK_SLOTS)
	) u_slot_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	ptts_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.res_in    (res),
		.can_push  (can_push),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_out   (res_out)
	);

	assign status_code    = res_out.status_code;
	assign dispatch_valid = res_out.dispatch_valid;
	assign dispatch_slot  = res_out.dispatch_slot;
	assign last_result    = res_out.last_result;

	always_comb begin
		state_d      = state_q;
		rd_cnt_d     = rd_cnt_q;
		proc_valid_d = proc_valid_s1;
		proc_slot_d  = proc_slot_s1;
		pend_valid_d = pend_valid_q;
		pend_slot_d  = pend_slot_q;
		disp_cnt_d   = disp_cnt_q;
		rd_en        = 1'b0;
		rd_addr      = '0;
		wr_en        = 1'b0;
		wr_addr      = req_addr_q;
		wr_data      = rd_data;
		push         = 1'b0;
		res          = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					rd_en = 1'b1;
					if (req_type == REQ_TICK) begin
						// slot 0 read now, walk starts next cycle
						rd_addr      = '0;
						rd_cnt_d     = CW'(1);
						proc_valid_d = 1'b1;
						proc_slot_d  = '0;
						pend_valid_d = 1'b0;
						disp_cnt_d   = '0;
						state_d      = ST_WALK;
					end else begin
						rd_addr = in_range_in ? SW'(slot_index) : '0;
						state_d = ST_REQ;
					end
				end
			end
			ST_REQ: begin
				if (can_push) begin
					push            = 1'b1;
					res.last_result = 1'b1;
					state_d         = ST_IDLE;
					case (req_q)
						REQ_CREATE: begin
							if (!req_in_range_q || rd_data.occupied || !handler_q) begin
								res.status_code = 1'b1;
							end else begin
								wr_en               = 1'b1;
								wr_data.occupied    = 1'b1;
								wr_data.run_state   = RS_RESUMED;
								wr_data.period      = period_q;
								wr_data.delay       = delay_q;
								wr_data.has_handler = 1'b1;
							end
						end
						REQ_SUSPEND: begin
							wr_en             = req_in_range_q && rd_data.occupied;
							wr_data.run_state = RS_SUSPENDED;
						end
						REQ_RESUME: begin
							wr_en             = req_in_range_q && rd_data.occupied;
							wr_data.run_state = RS_RESUMED;
						end
						REQ_DELETE: begin
							// delay is left as it was
							wr_en               = req_in_range_q;
							wr_data.occupied    = 1'b0;
							wr_data.run_state   = RS_EMPTY;
							wr_data.period      = '0;
							wr_data.has_handler = 1'b0;
						end
						default: begin
						end
					endcase
				end
			end
			ST_WALK: begin
				if (walk_go) begin
					wr_en   = resumed;
					wr_addr = proc_slot_s1;
					if (dispatch) begin
						wr_data.delay = rd_data.period - TICKS_W'(1);
					end else if (rd_data.delay != '0) begin
						wr_data.delay = rd_data.delay - TICKS_W'(1);
					end
					if (emit_prev) begin
						push               = 1'b1;
						res.dispatch_valid = 1'b1;
						res.dispatch_slot  = pend_slot_q;
					end
					if (record) begin
						pend_valid_d = 1'b1;
						pend_slot_d  = SLOT_W'(proc_slot_s1);
						disp_cnt_d   = disp_cnt_q + NW'(1);
					end
					if (rd_cnt_q < CW'(TASK_SLOTS)) begin
						rd_en       = 1'b1;
						rd_addr     = rd_cnt_q[SW-1:0];
						proc_slot_d = rd_cnt_q[SW-1:0];
						rd_cnt_d    = rd_cnt_q + CW'(1);
					end else begin
						proc_valid_d = 1'b0;
						state_d      = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				// last dispatch of the tick, or the empty result
				if (can_push) begin
					push               = 1'b1;
					res.last_result    = 1'b1;
					res.dispatch_valid = pend_valid_q;
					res.dispatch_slot  = pend_valid_q ? pend_slot_q : '0;
					pend_valid_d       = 1'b0;
					state_d            = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rd_cnt_q      <= '0;
			proc_valid_s1 <= 1'b0;
			pend_valid_q  <= 1'b0;
			disp_cnt_q    <= '0;
		end else begin
			state_q       <= state_d;
			rd_cnt_q      <= rd_cnt_d;
			proc_valid_s1 <= proc_valid_d;
			pend_valid_q  <= pend_valid_d;
			disp_cnt_q    <= disp_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		proc_slot_s1 <= proc_slot_d;
		pend_slot_q  <= pend_slot_d;
		if (in_accept) begin
			req_q          <= req_type_t'(req_type);
			req_addr_q     <= in_range_in ? SW'(slot_index) : '0;
			req_in_range_q <= in_range_in;
			period_q       <= period_ticks;
			delay_q        <= start_delay;
			handler_q      <= has_handler;
		end
	end

	// the walk never reads the slot it is writing back
	a_no_rw_same_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (rd_addr != wr_addr))
		else $error("slot table read and write hit the same slot");

	// an entry awaits processing only during a tick walk
	a_proc_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		proc_valid_s1 |-> (state_q == ST_WALK))
		else $error("walk stage valid outside the tick walk");

	// results are never pushed over an unconsumed one
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> can_push)
		else $error("result pushed while output register is blocked");

	// dispatch count stays within the result limit
	a_disp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		disp_cnt_q <= NW'(MAX_RESULTS))
		else $error("dispatch count beyond result limit");

	// a dispatch never carries a refusal
	a_disp_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && dispatch_valid) |-> !status_code)
		else $error("dispatch result with error status");

endmodule
